[rtl/sl_pkg.sv]
`timescale 1ns / 1ps
package sl_pkg;

   // Token kinds on the result channel.
   localparam logic [5:0] K_END      = 6'd0;
   localparam logic [5:0] K_NUMBER   = 6'd1;
   localparam logic [5:0] K_STRING   = 6'd2;
   localparam logic [5:0] K_CHAR     = 6'd3;
   localparam logic [5:0] K_IDENT    = 6'd4;
   localparam logic [5:0] K_KEYWORD0 = 6'd5;
   localparam logic [5:0] K_COMMA    = 6'd13;
   localparam logic [5:0] K_LPAREN   = 6'd14;
   localparam logic [5:0] K_RPAREN   = 6'd15;
   localparam logic [5:0] K_SEMI     = 6'd16;
   localparam logic [5:0] K_LBRACE   = 6'd17;
   localparam logic [5:0] K_RBRACE   = 6'd18;
   localparam logic [5:0] K_LBRACKET = 6'd19;
   localparam logic [5:0] K_RBRACKET = 6'd20;
   localparam logic [5:0] K_PAIR0    = 6'd21;
   localparam logic [5:0] K_ASSIGN   = 6'd27;
   localparam logic [5:0] K_MINUS    = 6'd28;
   localparam logic [5:0] K_PLUS     = 6'd29;
   localparam logic [5:0] K_STAR     = 6'd30;
   localparam logic [5:0] K_SLASH    = 6'd31;
   localparam logic [5:0] K_PERCENT  = 6'd32;
   localparam logic [5:0] K_ERROR    = 6'd33;
   localparam logic [5:0] K_NONE     = 6'd0;

   // Lookahead operator codes.
   localparam logic [2:0] OP_BAR   = 3'd0;
   localparam logic [2:0] OP_AMP   = 3'd1;
   localparam logic [2:0] OP_EQ    = 3'd2;
   localparam logic [2:0] OP_BANG  = 3'd3;
   localparam logic [2:0] OP_PLUS  = 3'd4;
   localparam logic [2:0] OP_MINUS = 3'd5;

   localparam logic [15:0] MAX16 = 16'hFFFF;
   localparam int QDEPTH = 4;

   // Keyword spellings, zero padded.
   localparam logic [7:0] KW_TEXT [8][8] = '{
      '{"f", "o", "r", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
      '{"w", "h", "i", "l", "e", 8'h0, 8'h0, 8'h0},
      '{"d", "o", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
      '{"i", "f", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
      '{"e", "l", "s", "e", 8'h0, 8'h0, 8'h0, 8'h0},
      '{"t", "r", "u", "e", 8'h0, 8'h0, 8'h0, 8'h0},
      '{"f", "a", "l", "s", "e", 8'h0, 8'h0, 8'h0},
      '{"i", "n", "c", "l", "u", "d", "e", 8'h0}
   };
   localparam logic [2:0] KW_LEN [8] = '{3'd3, 3'd5, 3'd2, 3'd2, 3'd4, 3'd4, 3'd5, 3'd7};

   typedef enum logic [2:0] {
      M_IDLE, M_NUMBER, M_IDENT, M_STRING, M_CHAR_VALUE, M_CHAR_CLOSE, M_OPERATOR, M_STOPPED
   } mode_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] offset;
      logic [15:0] length;
      logic [15:0] line;
      logic [15:0] column;
      logic [7:0]  value;
      logic        last;
   } token_type;

   // Lexer state carried from word to word.
   typedef struct packed {
      mode_type    mode;
      logic [2:0]  pend;
      logic [15:0] tstart;
      logic [15:0] tlen;
      logic [7:0]  kwm;
      logic [15:0] tline;
      logic [15:0] tcol;
      logic [7:0]  cval;
   } lex_state_type;

   // Tokens handed together from the front end to the queue.
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

   function automatic logic [15:0] inc_sat(input logic [15:0] v);
      return (v == MAX16) ? MAX16 : v + 16'd1;
   endfunction

endpackage

[rtl/sl_front.sv]
`timescale 1ns / 1ps
module sl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              in_kind,
   input  logic [7:0]        in_byte,
   input  logic              room,
   output logic              in_ready,
   output sl_pkg::push_type  push
);

   typedef struct packed {
      sl_pkg::lex_state_type st;
      logic                  emit;
      sl_pkg::token_type     tok;
   } start_type;

   sl_pkg::lex_state_type st_ff, st_in, st_base;
   logic [15:0] pos_ff, pos_in, line_ff, line_in, col_ff, col_in;
   start_type sr;
   sl_pkg::token_type word_tok, t0, t1;
   logic [1:0] n;
   logic [5:0] single_op;

   function automatic sl_pkg::token_type mk(input logic [5:0] k, input logic [15:0] o,
                                            input logic [15:0] l, input logic [15:0] ln,
                                            input logic [15:0] cl, input logic [7:0] v);
      sl_pkg::token_type t;
      t.kind = k;
      t.offset = o;
      t.length = l;
      t.line = ln;
      t.column = cl;
      t.value = v;
      t.last = 1'b0;
      return t;
   endfunction

   function automatic logic digit_byte(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic alpha_byte(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   // Drop every keyword that is already complete or whose next letter differs from this byte.
   function automatic logic [7:0] kw_clear(input logic [7:0] m, input logic [15:0] len,
                                           input logic [7:0] c);
      logic [7:0] r;
      r = m;
      for (int k = 0; k < 8; k++) begin
         if (len >= {13'd0, sl_pkg::KW_LEN[k]}) begin
            r[k] = 1'b0;
         end else if (sl_pkg::KW_TEXT[k][len[2:0]] != c) begin
            r[k] = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         ",": k = sl_pkg::K_COMMA;
         "(": k = sl_pkg::K_LPAREN;
         ")": k = sl_pkg::K_RPAREN;
         ";": k = sl_pkg::K_SEMI;
         "{": k = sl_pkg::K_LBRACE;
         "}": k = sl_pkg::K_RBRACE;
         "[": k = sl_pkg::K_LBRACKET;
         "]": k = sl_pkg::K_RBRACKET;
         "*": k = sl_pkg::K_STAR;
         "/": k = sl_pkg::K_SLASH;
         "%": k = sl_pkg::K_PERCENT;
         default: k = sl_pkg::K_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] op_second(input logic [2:0] p);
      logic [7:0] c;
      case (p)
         sl_pkg::OP_BAR:   c = "|";
         sl_pkg::OP_AMP:   c = "&";
         sl_pkg::OP_EQ:    c = "=";
         sl_pkg::OP_BANG:  c = "=";
         sl_pkg::OP_PLUS:  c = "+";
         sl_pkg::OP_MINUS: c = "-";
         default:          c = "|";
      endcase
      return c;
   endfunction

   function automatic logic [5:0] op_single(input logic [2:0] p);
      logic [5:0] k;
      case (p)
         sl_pkg::OP_EQ:    k = sl_pkg::K_ASSIGN;
         sl_pkg::OP_PLUS:  k = sl_pkg::K_PLUS;
         sl_pkg::OP_MINUS: k = sl_pkg::K_MINUS;
         default:          k = sl_pkg::K_NONE;
      endcase
      return k;
   endfunction

   // Open a new token on a byte seen between tokens.
   function automatic start_type start_tok(input sl_pkg::lex_state_type s,
                                           input logic [7:0] c, input logic [15:0] pos,
                                           input logic [15:0] ln, input logic [15:0] cl);
      start_type r;
      logic [5:0] sk;
      r.st = s;
      r.emit = 1'b0;
      r.tok = mk(sl_pkg::K_ERROR, pos, 16'd0, ln, cl, 8'd0);
      sk = single_kind(c);
      if (c == " " || c == 8'h0A || c == 8'h09 || c == 8'h0D) begin
         r.emit = 1'b0;
      end else begin
         r.st.tline = ln;
         r.st.tcol = cl;
         if (digit_byte(c) || alpha_byte(c)) begin
            r.st.mode = digit_byte(c) ? sl_pkg::M_NUMBER : sl_pkg::M_IDENT;
            r.st.tstart = pos;
            r.st.kwm = kw_clear(8'hFF, 16'd0, c);
            r.st.tlen = 16'd1;
         end else if (c == 8'h22 || c == 8'h27) begin
            r.st.mode = (c == 8'h22) ? sl_pkg::M_STRING : sl_pkg::M_CHAR_VALUE;
            r.st.tstart = sl_pkg::inc_sat(pos);
            r.st.tlen = 16'd0;
         end else if (sk != sl_pkg::K_NONE) begin
            r.emit = 1'b1;
            r.tok = mk(sk, pos, 16'd1, ln, cl, 8'd0);
         end else if (c == "|" || c == "&" || c == "=" || c == "!" || c == "+" || c == "-") begin
            r.st.mode = sl_pkg::M_OPERATOR;
            r.st.tstart = pos;
            case (c)
               "|":     r.st.pend = sl_pkg::OP_BAR;
               "&":     r.st.pend = sl_pkg::OP_AMP;
               "=":     r.st.pend = sl_pkg::OP_EQ;
               "!":     r.st.pend = sl_pkg::OP_BANG;
               "+":     r.st.pend = sl_pkg::OP_PLUS;
               default: r.st.pend = sl_pkg::OP_MINUS;
            endcase
         end else begin
            r.emit = 1'b1;
            r.st.mode = sl_pkg::M_STOPPED;
         end
      end
      return r;
   endfunction

   assign in_ready = room;

   // Shared token builders.
   always_comb begin
      st_base = st_ff;
      st_base.mode = sl_pkg::M_IDLE;
      sr = start_tok(st_base, in_byte, pos_ff, line_ff, col_ff);
      word_tok = mk(sl_pkg::K_NUMBER, st_ff.tstart, st_ff.tlen, st_ff.tline, st_ff.tcol, 8'd0);
      if (st_ff.mode == sl_pkg::M_IDENT) begin
         word_tok.kind = sl_pkg::K_IDENT;
         for (int k = 0; k < 8; k++) begin
            if (st_ff.kwm[k] && st_ff.tlen == {13'd0, sl_pkg::KW_LEN[k]}) begin
               word_tok.kind = sl_pkg::K_KEYWORD0 + 6'(k);
            end
         end
      end
      single_op = op_single(st_ff.pend);
   end

   // Mode update and token emission for one word.
   always_comb begin
      st_in = st_ff;
      pos_in = pos_ff;
      line_in = line_ff;
      col_in = col_ff;
      n = 2'd0;
      t0 = mk(sl_pkg::K_END, pos_ff, 16'd0, line_ff, col_ff, 8'd0);
      t1 = t0;
      if (st_ff.mode == sl_pkg::M_STOPPED) begin
         n = 2'd0;
      end else if (in_kind) begin
         st_in.mode = sl_pkg::M_STOPPED;
         unique case (st_ff.mode)
            sl_pkg::M_NUMBER, sl_pkg::M_IDENT: begin
               t0 = word_tok;
               n = 2'd2;
            end
            sl_pkg::M_OPERATOR: begin
               if (single_op == sl_pkg::K_NONE) begin
                  t0 = mk(sl_pkg::K_ERROR, st_ff.tstart, 16'd0, st_ff.tline, st_ff.tcol, 8'd0);
                  n = 2'd1;
               end else begin
                  t0 = mk(single_op, st_ff.tstart, 16'd1, st_ff.tline, st_ff.tcol, 8'd0);
                  n = 2'd2;
               end
            end
            sl_pkg::M_STRING, sl_pkg::M_CHAR_VALUE, sl_pkg::M_CHAR_CLOSE: begin
               t0 = mk(sl_pkg::K_ERROR, pos_ff, 16'd0, line_ff, col_ff, 8'd0);
               n = 2'd1;
            end
            default: begin
               n = 2'd1;
            end
         endcase
      end else begin
         pos_in = sl_pkg::inc_sat(pos_ff);
         if (in_byte == 8'h0A) begin
            line_in = sl_pkg::inc_sat(line_ff);
            col_in = 16'd1;
         end else begin
            col_in = sl_pkg::inc_sat(col_ff);
         end
         unique case (st_ff.mode)
            sl_pkg::M_NUMBER, sl_pkg::M_IDENT: begin
               if ((st_ff.mode == sl_pkg::M_NUMBER && digit_byte(in_byte)) ||
                   (st_ff.mode == sl_pkg::M_IDENT && alpha_byte(in_byte))) begin
                  st_in.kwm = kw_clear(st_ff.kwm, st_ff.tlen, in_byte);
                  st_in.tlen = sl_pkg::inc_sat(st_ff.tlen);
               end else begin
                  t0 = word_tok;
                  st_in = sr.st;
                  t1 = sr.tok;
                  n = sr.emit ? 2'd2 : 2'd1;
               end
            end
            sl_pkg::M_STRING: begin
               if (in_byte == 8'h22) begin
                  st_in.mode = sl_pkg::M_IDLE;
                  t0 = mk(sl_pkg::K_STRING, st_ff.tstart, st_ff.tlen, st_ff.tline,
                          st_ff.tcol, 8'd0);
                  n = 2'd1;
               end else begin
                  st_in.tlen = sl_pkg::inc_sat(st_ff.tlen);
               end
            end
            sl_pkg::M_CHAR_VALUE: begin
               st_in.cval = in_byte;
               st_in.mode = sl_pkg::M_CHAR_CLOSE;
            end
            sl_pkg::M_CHAR_CLOSE: begin
               n = 2'd1;
               if (in_byte == 8'h27) begin
                  st_in.mode = sl_pkg::M_IDLE;
                  t0 = mk(sl_pkg::K_CHAR, st_ff.tstart, 16'd1, st_ff.tline, st_ff.tcol,
                          st_ff.cval);
               end else begin
                  st_in.mode = sl_pkg::M_STOPPED;
                  t0 = mk(sl_pkg::K_ERROR, pos_ff, 16'd0, line_ff, col_ff, 8'd0);
               end
            end
            sl_pkg::M_OPERATOR: begin
               st_in.mode = sl_pkg::M_IDLE;
               if (in_byte == op_second(st_ff.pend)) begin
                  t0 = mk(sl_pkg::K_PAIR0 + {3'd0, st_ff.pend}, st_ff.tstart, 16'd2,
                          st_ff.tline, st_ff.tcol, 8'd0);
                  n = 2'd1;
               end else if (single_op == sl_pkg::K_NONE) begin
                  st_in.mode = sl_pkg::M_STOPPED;
                  t0 = mk(sl_pkg::K_ERROR, st_ff.tstart, 16'd0, st_ff.tline, st_ff.tcol, 8'd0);
                  n = 2'd1;
               end else begin
                  t0 = mk(single_op, st_ff.tstart, 16'd1, st_ff.tline, st_ff.tcol, 8'd0);
                  st_in = sr.st;
                  t1 = sr.tok;
                  n = sr.emit ? 2'd2 : 2'd1;
               end
            end
            default: begin
               st_in = sr.st;
               t0 = sr.tok;
               n = sr.emit ? 2'd1 : 2'd0;
            end
         endcase
      end
      // Mark the last token of this word.
      t0.last = (n == 2'd1);
      t1.last = 1'b1;
   end

   always_comb begin
      push.count = (in_valid && in_ready) ? n : 2'd0;
      push.tok0 = t0;
      push.tok1 = t1;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.mode <= sl_pkg::M_IDLE;
         st_ff.pend <= sl_pkg::OP_BAR;
         st_ff.tstart <= 16'd0;
         st_ff.tlen <= 16'd0;
         st_ff.kwm <= 8'hFF;
         st_ff.tline <= 16'd1;
         st_ff.tcol <= 16'd1;
         st_ff.cval <= 8'd0;
         pos_ff <= 16'd0;
         line_ff <= 16'd1;
         col_ff <= 16'd1;
      end else if (in_valid && in_ready) begin
         st_ff <= st_in;
         pos_ff <= pos_in;
         line_ff <= line_in;
         col_ff <= col_in;
      end
   end

endmodule

[rtl/sl_queue.sv]
`timescale 1ns / 1ps
module sl_queue (
   input  logic              clock,
   input  logic              reset,
   input  sl_pkg::push_type  push,
   input  logic              pop_ready,
   output logic              room,
   output logic              head_valid,
   output sl_pkg::token_type head
);

   localparam int AW = $clog2(sl_pkg::QDEPTH);
   localparam int CW = $clog2(sl_pkg::QDEPTH + 1);

   sl_pkg::token_type mem [sl_pkg::QDEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic pop;

   assign head_valid = (count_ff != '0);
   assign head = mem[rd_ff];
   assign pop = head_valid && pop_ready;
   // Room for the two tokens one word may cause.
   assign room = (count_ff <= CW'(sl_pkg::QDEPTH - 2));

   // Pointer and fill count update.
   always_comb begin
      wr_in = wr_ff + AW'(push.count);
      rd_in = rd_ff + AW'(pop);
      count_in = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   // Token storage.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         mem[wr_ff + AW'(1)] <= push.tok1;
      end
   end

endmodule

[rtl/source_lexer.sv]
`timescale 1ns / 1ps
// Streaming tokenizer for a small C-like language.
// The req_ channel carries one source byte per word (req_tuser low), or an
// end-of-input mark (req_tuser high, byte ignored). The rsp_ channel carries
// tokens: kind in rsp_tuser, offset, length, line, column and char value in
// rsp_tdata, and rsp_tlast on the last token that one input word causes.
// A front end updates the lexer mode for one byte per cycle while the queue
// has room and emits up to two tokens into a four-entry token queue; the
// queue head drives the rsp_ port. Tokens are registered in the queue before
// they show on rsp_. Throughput: one byte per cycle while tokens drain,
// limited by the queue draining one token per cycle; a byte that completes
// two tokens puts both in the queue to drain. When the receiver stalls, the
// queue fills and req_tready drops once fewer than two entries are free.
// After an end or error token the block takes bytes but emits nothing until
// reset. Reset returns to between tokens at line 1, column 1, offset 0, and
// empties the queue.
module source_lexer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] char_byte
   input  logic        req_tuser,  // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // [15:0] start_offset, [31:16] text_length,
                                   // [47:32] start_line, [63:48] start_column,
                                   // [71:64] const_value
   output logic [5:0]  rsp_tuser,  // [5:0] token_kind
   output logic        rsp_tlast
);

   sl_pkg::push_type  push;
   sl_pkg::token_type head;
   logic room;

   sl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_kind  (req_tuser),
      .in_byte  (req_tdata),
      .room     (room),
      .in_ready (req_tready),
      .push     (push)
   );

   sl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop_ready  (rsp_tready),
      .room       (room),
      .head_valid (rsp_tvalid),
      .head       (head)
   );

   // Pack the queue head onto the result port.
   assign rsp_tdata = {head.value, head.column, head.line, head.length, head.offset};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
